FILE: design/zpr_pkg.sv
// shared types, constants and tables for the pinch zoom rotate calculator
`default_nettype none
package zpr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int NORM_STEPS   = 6;
    localparam int NORM_BITS    = 40;
    localparam int Q_BITS       = 31;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DOT_W  = PROD_W + 1;
    localparam int ACC_W  = 2 * Q_BITS + SQ_W + 3;
    localparam int XY_W   = NORM_BITS + 4;
    localparam int Z_W    = ANG_FRAC + 10;
    localparam int ZOOM_W = 30;
    localparam int TURN_W = 25;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam int BIT_W  = $clog2(Q_BITS);
    localparam int NSTEP_W = $clog2(NORM_STEPS);

    localparam int RND_SH   = ANG_FRAC - FRAC_BITS;
    localparam int RND_HALF = (RND_SH > 0) ? (1 << ((RND_SH > 0) ? RND_SH - 1 : 0)) : 0;

    localparam logic [ZOOM_W-1:0] ZOOM_LIMIT = ZOOM_W'((64'd1 << (ZOOM_W - 1)) - 64'd1);
    localparam logic [TURN_W-1:0] TURN_LIMIT = {TURN_W{1'b1}};

    // pipeline stage numbers, counted from the input register
    localparam int ST_FRONT = 3;
    localparam int ST_PREP  = ST_FRONT + 1;
    localparam int ST_NORM0 = ST_PREP + 1;
    localparam int ST_CORD0 = ST_NORM0 + NORM_STEPS;
    localparam int ST_OUT   = ST_CORD0 + CORDIC_STEPS;
    localparam int ST_SQ0   = ST_PREP + 1;
    localparam int ST_ZFIN  = ST_SQ0 + Q_BITS;
    localparam int ZDLY     = ST_OUT - ST_ZFIN;

    // atan(2^-i) in units of 2^-24 degree
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
        32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
        32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
        32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
        32'd115, 32'd57, 32'd29, 32'd14, 32'd7
    };

    typedef struct packed {
        logic [COORD_BITS-1:0] start_a_x;
        logic [COORD_BITS-1:0] start_a_y;
        logic [COORD_BITS-1:0] now_a_x;
        logic [COORD_BITS-1:0] now_a_y;
        logic [COORD_BITS-1:0] start_b_x;
        logic [COORD_BITS-1:0] start_b_y;
        logic [COORD_BITS-1:0] now_b_x;
        logic [COORD_BITS-1:0] now_b_y;
    } t_in;

    typedef struct packed {
        logic              zoom_valid;
        logic [ZOOM_W-1:0] zoom_amount;
        logic              turn_valid;
        logic [TURN_W-1:0] turn_degrees;
    } t_out;

    typedef struct packed {
        logic zv;
        logic grew;
    } t_zoom_ctl;

    typedef struct packed {
        logic neg;
        logic tv;
        logic half;
    } t_ang_ctl;

    typedef struct packed {
        logic              zoom_valid;
        logic [ZOOM_W-1:0] zoom_amount;
    } t_zres;

endpackage
`default_nettype wire

FILE: design/zpr_if.sv
// valid/ready channel interfaces for input and result items
`default_nettype none
interface zpr_in_if
    import zpr_pkg::*;
;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface zpr_out_if
    import zpr_pkg::*;
;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/zpr_front.sv
// span differences, products and sums of the first three stages
`default_nettype none
module zpr_front
    import zpr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic [2:0]              i_en,
    input  wire t_in                     i_data,
    output logic        [SQ_W-1:0]       o_ss,
    output logic        [SQ_W-1:0]       o_sc,
    output logic signed [DOT_W-1:0]      o_dot,
    output logic signed [DOT_W-1:0]      o_crs
);
    logic signed [DIFF_W-1:0] r_sdx, r_sdy, r_cdx, r_cdy;
    logic signed [PROD_W-1:0] r_p_sxx, r_p_syy, r_p_cxx, r_p_cyy;
    logic signed [PROD_W-1:0] r_p_dx, r_p_dy, r_p_c1, r_p_c2;

    function automatic logic signed [DIFF_W-1:0] span(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        return $signed({1'b0, b}) - $signed({1'b0, a});
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sdx <= span(i_data.start_a_x, i_data.start_b_x);
            r_sdy <= span(i_data.start_a_y, i_data.start_b_y);
            r_cdx <= span(i_data.now_a_x, i_data.now_b_x);
            r_cdy <= span(i_data.now_a_y, i_data.now_b_y);
        end
        if (i_en[1]) begin
            r_p_sxx <= r_sdx * r_sdx;
            r_p_syy <= r_sdy * r_sdy;
            r_p_cxx <= r_cdx * r_cdx;
            r_p_cyy <= r_cdy * r_cdy;
            r_p_dx  <= r_cdx * r_sdx;
            r_p_dy  <= r_cdy * r_sdy;
            r_p_c1  <= r_cdx * r_sdy;
            r_p_c2  <= r_cdy * r_sdx;
        end
        if (i_en[2]) begin
            o_ss  <= SQ_W'(unsigned'(r_p_sxx) + unsigned'(r_p_syy));
            o_sc  <= SQ_W'(unsigned'(r_p_cxx) + unsigned'(r_p_cyy));
            o_dot <= DOT_W'(r_p_dx) + DOT_W'(r_p_dy);
            o_crs <= DOT_W'(r_p_c1) - DOT_W'(r_p_c2);
        end
    end
endmodule
`default_nettype wire

FILE: design/zpr_sqrt_cell.sv
// one bit of the span ratio square root search
`default_nettype none
module zpr_sqrt_cell
    import zpr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [BIT_W-1:0]    i_bit,
    input  wire t_zoom_ctl           i_ctl,
    input  wire logic [SQ_W-1:0]     i_big,
    input  wire logic [SQ_W-1:0]     i_small,
    input  wire logic [ACC_W-1:0]    i_p,
    input  wire logic [ACC_W-1:0]    i_qs,
    input  wire logic [Q_BITS-1:0]   i_q,
    output t_zoom_ctl                o_ctl,
    output logic      [SQ_W-1:0]     o_big,
    output logic      [SQ_W-1:0]     o_small,
    output logic      [ACC_W-1:0]    o_p,
    output logic      [ACC_W-1:0]    o_qs,
    output logic      [Q_BITS-1:0]   o_q
);
    logic [ACC_W-1:0] small_w, cand, rhs;
    logic             take;

    // (q + 2^b)^2 * small = p + q*small*2^(b+1) + small*2^(2b)
    always_comb begin
        small_w = ACC_W'(i_small);
        cand    = i_p + (i_qs << ({1'b0, i_bit} + 1'b1)) + (small_w << {i_bit, 1'b0});
        rhs     = ACC_W'(i_big) << (2 * FRAC_BITS);
        take    = (cand <= rhs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl   <= i_ctl;
            o_big   <= i_big;
            o_small <= i_small;
            o_p     <= take ? cand : i_p;
            o_qs    <= take ? (i_qs + (small_w << i_bit)) : i_qs;
            o_q     <= take ? (i_q | (Q_BITS'(1) << i_bit)) : i_q;
        end
    end
endmodule
`default_nettype wire

FILE: design/zpr_norm_cell.sv
// one binary step of the angle vector normalizing shift
`default_nettype none
module zpr_norm_cell
    import zpr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [NSTEP_W-1:0]    i_step,
    input  wire t_ang_ctl              i_ctl,
    input  wire logic [NORM_BITS-1:0]  i_x,
    input  wire logic [NORM_BITS-1:0]  i_y,
    output t_ang_ctl                   o_ctl,
    output logic      [NORM_BITS-1:0]  o_x,
    output logic      [NORM_BITS-1:0]  o_y
);
    logic [5:0] k;
    logic       fits;

    always_comb begin
        k    = 6'd32 >> i_step;
        fits = (((i_x | i_y) >> (NORM_BITS - int'(k))) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= i_ctl;
            o_x   <= fits ? (i_x << k) : i_x;
            o_y   <= fits ? (i_y << k) : i_y;
        end
    end
endmodule
`default_nettype wire

FILE: design/zpr_cordic_cell.sv
// one vectoring rotation of the angle search
`default_nettype none
module zpr_cordic_cell
    import zpr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic        [STEP_W-1:0] i_step,
    input  wire t_ang_ctl                 i_ctl,
    input  wire logic signed [XY_W-1:0]   i_x,
    input  wire logic signed [XY_W-1:0]   i_y,
    input  wire logic signed [Z_W-1:0]    i_z,
    output t_ang_ctl                      o_ctl,
    output logic signed      [XY_W-1:0]   o_x,
    output logic signed      [XY_W-1:0]   o_y,
    output logic signed      [Z_W-1:0]    o_z
);
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  t;

    always_comb begin
        xs = i_x >>> i_step;
        ys = i_y >>> i_step;
        t  = $signed(Z_W'(ATAN_TAB[i_step]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl <= i_ctl;
            if (!i_y[XY_W-1]) begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
                o_z <= i_z + t;
            end else begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
                o_z <= i_z - t;
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/pinch_zoom_rotate_calc_core.sv
// top level of the two-finger pinch zoom and rotate calculator
//
// usage: each input item carries start and current positions of two fingers;
// each one yields exactly one result item with zoom factor and turn angle.
// both channels are valid/ready; an item moves when valid and ready are high.
// the datapath is a 39-stage pipeline: three front stages (spans, products,
// sums), a prep stage, then 31 square root cells for the zoom and 6 shift
// cells plus 28 cordic cells for the angle, then one output stage.
// throughput: one item per cycle while the receiver takes results; each stage
// holds one item and moves it on whenever the next stage is free, so bubbles
// close up under back-pressure. when the receiver stalls, the output register
// holds its result and the stages behind it fill; input ready drops only when
// every stage is full. reset clears all stage valid flags; no result is
// offered until new items arrive. there are no configuration registers and
// no state between items.
`default_nettype none
module pinch_zoom_rotate_calc_core
    import zpr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    zpr_in_if.sink     i_in,
    zpr_out_if.source  o_out
);
    logic [ST_OUT:1]   r_v;
    logic [ST_OUT+1:1] en;
    logic [ST_OUT:1]   v_prev;

    always_comb begin
        en[ST_OUT+1] = o_out.ready;
        for (int i = ST_OUT; i >= 1; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign v_prev = {r_v[ST_OUT-1:1], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 1; i <= ST_OUT; i++) begin
                if (en[i]) begin
                    r_v[i] <= v_prev[i];
                end
            end
        end
    end

    assign i_in.ready  = en[1];
    assign o_out.valid = r_v[ST_OUT];

    // front stages
    logic        [SQ_W-1:0]  ss, sc;
    logic signed [DOT_W-1:0] dot, crs;

    zpr_front u_front (
        .i_clk  (i_clk),
        .i_en   (en[ST_FRONT:1]),
        .i_data (i_in.data),
        .o_ss   (ss),
        .o_sc   (sc),
        .o_dot  (dot),
        .o_crs  (crs)
    );

    // prep stage
    t_zoom_ctl              r_zctl;
    logic [SQ_W-1:0]        r_big, r_small;
    t_ang_ctl               r_actl;
    logic [NORM_BITS-1:0]   r_ax, r_ay;
    logic [DOT_W-1:0]       crs_abs, dot_neg;

    always_comb begin
        crs_abs = crs[DOT_W-1] ? unsigned'(-crs) : unsigned'(crs);
        dot_neg = unsigned'(-dot);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_PREP]) begin
            r_zctl.zv   <= (ss != '0) && (sc != '0) && (ss != sc);
            r_zctl.grew <= (sc > ss);
            r_big       <= (sc > ss) ? sc : ss;
            r_small     <= (sc > ss) ? ss : sc;
            r_actl.neg  <= crs[DOT_W-1];
            r_actl.tv   <= (crs != '0);
            r_actl.half <= dot[DOT_W-1];
            // a negative dot product is turned by -90 degrees first
            if (dot[DOT_W-1]) begin
                r_ax <= NORM_BITS'(crs_abs);
                r_ay <= NORM_BITS'(dot_neg);
            end else begin
                r_ax <= NORM_BITS'(unsigned'(dot));
                r_ay <= NORM_BITS'(crs_abs);
            end
        end
    end

    // zoom: square root chain
    t_zoom_ctl          sq_ctl   [Q_BITS+1];
    logic [SQ_W-1:0]    sq_big   [Q_BITS+1];
    logic [SQ_W-1:0]    sq_small [Q_BITS+1];
    logic [ACC_W-1:0]   sq_p     [Q_BITS+1];
    logic [ACC_W-1:0]   sq_qs    [Q_BITS+1];
    logic [Q_BITS-1:0]  sq_q     [Q_BITS+1];

    assign sq_ctl[0]   = r_zctl;
    assign sq_big[0]   = r_big;
    assign sq_small[0] = r_small;
    assign sq_p[0]     = '0;
    assign sq_qs[0]    = '0;
    assign sq_q[0]     = '0;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_sqrt
        zpr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (en[ST_SQ0+g]),
            .i_bit   (BIT_W'(Q_BITS - 1 - g)),
            .i_ctl   (sq_ctl[g]),
            .i_big   (sq_big[g]),
            .i_small (sq_small[g]),
            .i_p     (sq_p[g]),
            .i_qs    (sq_qs[g]),
            .i_q     (sq_q[g]),
            .o_ctl   (sq_ctl[g+1]),
            .o_big   (sq_big[g+1]),
            .o_small (sq_small[g+1]),
            .o_p     (sq_p[g+1]),
            .o_qs    (sq_qs[g+1]),
            .o_q     (sq_q[g+1])
        );
    end

    // zoom finish and delay to line up with the angle path
    t_zres             r_zd [ZDLY];
    t_zres             zfin;
    logic [Q_BITS-1:0] mag;
    logic [ZOOM_W-1:0] mag_sat;

    always_comb begin
        mag     = sq_q[Q_BITS] - (Q_BITS'(1) << FRAC_BITS);
        mag_sat = (mag > Q_BITS'(ZOOM_LIMIT)) ? ZOOM_LIMIT : ZOOM_W'(mag);
        zfin.zoom_valid  = sq_ctl[Q_BITS].zv;
        if (!sq_ctl[Q_BITS].zv) begin
            zfin.zoom_amount = '0;
        end else if (sq_ctl[Q_BITS].grew) begin
            zfin.zoom_amount = mag_sat;
        end else begin
            zfin.zoom_amount = -mag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ZDLY; j++) begin
            if (en[ST_ZFIN+j]) begin
                r_zd[j] <= (j == 0) ? zfin : r_zd[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // angle: normalizing shift chain
    t_ang_ctl             nm_ctl [NORM_STEPS+1];
    logic [NORM_BITS-1:0] nm_x   [NORM_STEPS+1];
    logic [NORM_BITS-1:0] nm_y   [NORM_STEPS+1];

    assign nm_ctl[0] = r_actl;
    assign nm_x[0]   = r_ax;
    assign nm_y[0]   = r_ay;

    for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
        zpr_norm_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en[ST_NORM0+g]),
            .i_step (NSTEP_W'(g)),
            .i_ctl  (nm_ctl[g]),
            .i_x    (nm_x[g]),
            .i_y    (nm_y[g]),
            .o_ctl  (nm_ctl[g+1]),
            .o_x    (nm_x[g+1]),
            .o_y    (nm_y[g+1])
        );
    end

    // angle: cordic chain; one more doubling brings the larger part past 2^40
    t_ang_ctl               cd_ctl [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_x   [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_y   [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cd_z   [CORDIC_STEPS+1];

    assign cd_ctl[0] = nm_ctl[NORM_STEPS];
    assign cd_x[0]   = $signed(XY_W'({nm_x[NORM_STEPS], 1'b0}));
    assign cd_y[0]   = $signed(XY_W'({nm_y[NORM_STEPS], 1'b0}));
    assign cd_z[0]   = nm_ctl[NORM_STEPS].half ? $signed(Z_W'(90) << ANG_FRAC) : '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        zpr_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en[ST_CORD0+g]),
            .i_step (STEP_W'(g)),
            .i_ctl  (cd_ctl[g]),
            .i_x    (cd_x[g]),
            .i_y    (cd_y[g]),
            .i_z    (cd_z[g]),
            .o_ctl  (cd_ctl[g+1]),
            .o_x    (cd_x[g+1]),
            .o_y    (cd_y[g+1]),
            .o_z    (cd_z[g+1])
        );
    end

    // output stage: clamp, fold by cross sign, round and saturate
    localparam logic [Z_W-1:0] Z180 = Z_W'(180) << ANG_FRAC;
    localparam logic [Z_W-1:0] Z360 = Z_W'(360) << ANG_FRAC;

    logic signed [Z_W-1:0] zr;
    logic [Z_W-1:0]        zc, a, ar;
    logic [TURN_W-1:0]     turn;
    t_out                  n_out, r_out;

    always_comb begin
        zr = cd_z[CORDIC_STEPS];
        if (zr[Z_W-1]) begin
            zc = '0;
        end else if (unsigned'(zr) > Z180) begin
            zc = Z180;
        end else begin
            zc = unsigned'(zr);
        end
        a  = cd_ctl[CORDIC_STEPS].neg ? zc : (Z360 - zc);
        ar = (a + Z_W'(RND_HALF)) >> RND_SH;
        turn = (ar > Z_W'(TURN_LIMIT)) ? TURN_LIMIT : TURN_W'(ar);
        n_out.zoom_valid   = r_zd[ZDLY-1].zoom_valid;
        n_out.zoom_amount  = r_zd[ZDLY-1].zoom_amount;
        n_out.turn_valid   = cd_ctl[CORDIC_STEPS].tv;
        n_out.turn_degrees = cd_ctl[CORDIC_STEPS].tv ? turn : '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out.data = r_out;
endmodule
`default_nettype wire

FILE: design/zpr_checker.sv
// port-level assertions for the calculator, bound to the top level
`default_nettype none
module zpr_checker
    import zpr_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_zoom_valid,
    input wire logic [ZOOM_W-1:0] i_zoom_amount,
    input wire logic              i_turn_valid,
    input wire logic [TURN_W-1:0] i_turn_degrees
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // with nothing waiting at the output the pipeline has room
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_zoom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_zoom_valid |-> i_zoom_amount == '0)
        else $error("zoom amount set without zoom");

    a_turn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_turn_valid |-> i_turn_degrees == '0)
        else $error("turn angle set without turn");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");
endmodule

bind pinch_zoom_rotate_calc_core zpr_checker u_zpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_zoom_valid   (o_out.data.zoom_valid),
    .i_zoom_amount  (o_out.data.zoom_amount),
    .i_turn_valid   (o_out.data.turn_valid),
    .i_turn_degrees (o_out.data.turn_degrees)
);
`default_nettype wire
